@@ sv/apf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apf_pkg: shared types and constants of the ADC pulse finder
// Payload structs, configuration register set and register indexes.
// ----------------------------------------------------------------------------
package apf_pkg;

	localparam int RAW_W     = 12;
	localparam int CAL_W     = 16;
	localparam int IDX_W     = 16;
	localparam int AREA_W    = 28;
	localparam int INT_W     = 32;
	localparam int CHAN_W    = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam int DEF_MAX_SAMPLES = 65536;
	localparam int DEF_ADC_BITS    = 12;

	localparam logic [CFG_IDX_W-1:0] REG_TRIG_LEVEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END_LEVEL  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ID = 2'd2;

	localparam logic [RAW_W-1:0]  RST_TRIG_LEVEL = 12'hFFF;
	localparam logic [RAW_W-1:0]  RST_END_LEVEL  = 12'h000;
	localparam logic [CHAN_W-1:0] RST_CHANNEL_ID = 16'h0000;

	typedef struct packed {
		logic [RAW_W-1:0]        raw_sample;
		logic signed [CAL_W-1:0] cal_sample;
		logic                    last_sample;
	} sample_t;

	typedef struct packed {
		logic [CHAN_W-1:0]       channel;
		logic [IDX_W-1:0]        start_index;
		logic [IDX_W-1:0]        end_index;
		logic [IDX_W-1:0]        peak_index;
		logic [AREA_W-1:0]       pulse_area;
		logic [RAW_W-1:0]        max_adc;
		logic signed [CAL_W-1:0] cal_amplitude;
		logic signed [INT_W-1:0] cal_integral;
	} pulse_t;

	typedef struct packed {
		logic [RAW_W-1:0]  trig_level;
		logic [RAW_W-1:0]  end_level;
		logic [CHAN_W-1:0] channel_id;
	} cfg_t;

endpackage

@@ sv/apf_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apf_core: pulse state and running accumulators
// Opens or updates a pulse with one registered sample and forms the result.
// ----------------------------------------------------------------------------
module apf_core import apf_pkg::*; #(
	parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  sample_t smp,
	input  cfg_t    cfg,
	output logic    res_valid,
	output pulse_t  res
);

	localparam int IDX_LIMIT_I = (MAX_SAMPLES - 1 > 65535) ? 65535 : MAX_SAMPLES - 1;
	localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(IDX_LIMIT_I);
	localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

	logic                    in_pulse_q;
	logic [IDX_W-1:0]        idx_q;
	logic [IDX_W-1:0]        start_q;
	logic [AREA_W-1:0]       area_q;
	logic [RAW_W-1:0]        max_q;
	logic [IDX_W-1:0]        peak_pos_q;
	logic [CAL_W-1:0]        peak_cal_q;
	logic [INT_W-1:0]        cal_acc_q;

	logic                    open_now;
	logic [AREA_W:0]         area_sum;
	logic [AREA_W-1:0]       area_nxt;
	logic [INT_W:0]          cal_sum;
	logic [INT_W-1:0]        cal_nxt;
	logic                    new_max;
	logic [RAW_W-1:0]        max_nxt;
	logic [IDX_W-1:0]        peak_pos_nxt;
	logic [CAL_W-1:0]        peak_cal_nxt;
	logic                    close_now;

	assign open_now = !in_pulse_q && (smp.raw_sample > cfg.trig_level);

	// Saturating raw area
	assign area_sum = {1'b0, area_q} + {{(AREA_W+1-RAW_W){1'b0}}, smp.raw_sample};
	assign area_nxt = area_sum[AREA_W] ? AREA_MAX : area_sum[AREA_W-1:0];

	// Saturating signed calibrated integral
	assign cal_sum = {cal_acc_q[INT_W-1], cal_acc_q}
		+ {{(INT_W+1-CAL_W){smp.cal_sample[CAL_W-1]}}, smp.cal_sample};
	always_comb begin
		if (cal_sum[INT_W] != cal_sum[INT_W-1]) begin
			cal_nxt = cal_sum[INT_W] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
		end else begin
			cal_nxt = cal_sum[INT_W-1:0];
		end
	end

	// First maximum wins: strict compare
	assign new_max      = smp.raw_sample > max_q;
	assign max_nxt      = new_max ? smp.raw_sample : max_q;
	assign peak_pos_nxt = new_max ? idx_q : peak_pos_q;
	assign peak_cal_nxt = new_max ? smp.cal_sample : peak_cal_q;

	assign close_now = in_pulse_q && ((smp.raw_sample < cfg.end_level) || smp.last_sample);

	assign res_valid = close_now;

	always_comb begin
		res.channel       = cfg.channel_id;
		res.start_index   = start_q;
		res.end_index     = idx_q;
		res.peak_index    = peak_pos_nxt;
		res.pulse_area    = area_nxt;
		res.max_adc       = max_nxt;
		res.cal_amplitude = peak_cal_nxt;
		res.cal_integral  = cal_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pulse_q <= 1'b0;
			idx_q      <= '0;
			start_q    <= '0;
			area_q     <= '0;
			max_q      <= '0;
			peak_pos_q <= '0;
			peak_cal_q <= '0;
			cal_acc_q  <= '0;
		end else if (step) begin
			if (open_now) begin
				// opening sample always becomes the first maximum
				in_pulse_q <= !smp.last_sample;
				start_q    <= idx_q;
				area_q     <= {{(AREA_W-RAW_W){1'b0}}, smp.raw_sample};
				max_q      <= smp.raw_sample;
				peak_pos_q <= idx_q;
				peak_cal_q <= smp.cal_sample;
				cal_acc_q  <= {{(INT_W-CAL_W){smp.cal_sample[CAL_W-1]}}, smp.cal_sample};
			end else if (in_pulse_q) begin
				in_pulse_q <= !close_now;
				area_q     <= area_nxt;
				max_q      <= max_nxt;
				peak_pos_q <= peak_pos_nxt;
				peak_cal_q <= peak_cal_nxt;
				cal_acc_q  <= cal_nxt;
			end
			if (smp.last_sample) begin
				idx_q <= '0;
			end else if (idx_q < IDX_LIMIT) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

@@ sv/apf_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apf_out_reg: pulse result register
// Holds one finished pulse until the downstream side takes it.
// ----------------------------------------------------------------------------
module apf_out_reg import apf_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   load,
	input  pulse_t load_data,
	output logic   free,
	output logic   valid,
	input  logic   ready,
	output pulse_t data
);

	logic   valid_q;
	pulse_t data_q;

	assign free  = !valid_q || ready;
	assign valid = valid_q;
	assign data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			data_q <= load_data;
		end
	end

endmodule

@@ sv/adc_pulse_finder.sv @@
`timescale 1ns / 1ps
// A closing sample is held in stage 1; its result then loads the result register.
// Throughput: one sample per cycle while the result side keeps up; the single
// input stage and the result register set that figure.
// Reset: arst_n clears the pulse state, sample index, both stages and the
// registers to threshold 4095 masked to ADC_BITS, end level 0, channel 0.
// ----------------------------------------------------------------------------
// adc_pulse_finder: threshold and hysteresis pulse finder with integration
// Finds pulses in a stream of minibuffer samples and reports area, peak and
// calibrated integral of each closed pulse.
// ----------------------------------------------------------------------------
module adc_pulse_finder import apf_pkg::*; #(
	parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
	parameter int ADC_BITS    = DEF_ADC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  sample_t              in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output pulse_t               out_data
);

	// Raw values keep only the converter's bits
	localparam int RAW_KEEP = (ADC_BITS < RAW_W) ? ADC_BITS : RAW_W;
	localparam logic [RAW_W-1:0] ADC_MASK = RAW_W'((64'd1 << RAW_KEEP) - 64'd1);

	cfg_t    cfg_q;
	logic    valid_s1;
	sample_t smp_s1;
	logic    step;
	logic    res_valid;
	pulse_t  res;
	logic    out_free;

	// Configuration registers; write them only while the block is idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trig_level <= RST_TRIG_LEVEL & ADC_MASK;
			cfg_q.end_level  <= RST_END_LEVEL;
			cfg_q.channel_id <= RST_CHANNEL_ID;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_TRIG_LEVEL: cfg_q.trig_level <= cfg_wdata[RAW_W-1:0] & ADC_MASK;
				REG_END_LEVEL:  cfg_q.end_level  <= cfg_wdata[RAW_W-1:0] & ADC_MASK;
				REG_CHANNEL_ID: cfg_q.channel_id <= cfg_wdata[CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance the sample in stage 1 unless it closes a pulse and the result
	// register is still full.
	assign step     = valid_s1 && (!res_valid || out_free);
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Hold the sample; mask raw to the converter width on entry
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			smp_s1.raw_sample  <= in_data.raw_sample & ADC_MASK;
			smp_s1.cal_sample  <= in_data.cal_sample;
			smp_s1.last_sample <= in_data.last_sample;
		end
	end

	apf_core #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.smp      (smp_s1),
		.cfg      (cfg_q),
		.res_valid(res_valid),
		.res      (res)
	);

	// Result register parts the sample side from the result side
	apf_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step && res_valid),
		.load_data(res),
		.free     (out_free),
		.valid    (out_valid),
		.ready    (out_ready),
		.data     (out_data)
	);

endmodule
